// ===== hdl/rfci_pkg.sv =====
// Package for the readout frame card interleaver.
// Holds the default parameter values, register indexes and field widths.
// No dependencies; used by readout_frame_card_interleaver.
package rfci_pkg;

  localparam int MAX_FRAME_WORDS_DEF  = 2048;
  localparam int HEADER_WORDS_DEF     = 43;
  localparam int COLUMNS_PER_CARD_DEF = 8;
  localparam int MAX_CARDS_DEF        = 4;

  localparam int WORD_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CARD_MASK_W = 4;
  localparam int FRAME_LEN_W = 12;
  localparam int CARD_CNT_W  = 3;
  localparam int CARD_IDX_W  = 2;
  localparam int REG_IDX_W   = 1;

  localparam logic [REG_IDX_W-1:0] REG_CARD_MASK   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WORDS = 1'b1;

  localparam logic [CARD_MASK_W-1:0] CARD_MASK_RST   = 4'hf;
  localparam logic [FRAME_LEN_W-1:0] FRAME_WORDS_RST = 12'd1356;

endpackage

// ===== hdl/rfci_ram.sv =====
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on nothing; used for the frame banks of the interleaver.
module rfci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/readout_frame_card_interleaver.sv =====
// Top level of the readout frame card interleaver.
// Depends on rfci_pkg and on rfci_ram, which holds both frame banks.
//
// The block takes one frame word per beat and writes it into one of two frame
// banks, moving each card-major data word to its row-major, card-interleaved
// place, while the previous frame is read out of the other bank in order. It
// takes one input beat per cycle when the output side keeps up; each emitted
// word is read into the read register of the bank memory and then moved into
// the output register; a stall of the output holds it in either. The output runs
// exactly one frame late and nothing is emitted for the first frame after
// reset. Card mask and frame length are sampled at the first word of each frame.
module readout_frame_card_interleaver #(
  parameter int MAX_FRAME_WORDS  = rfci_pkg::MAX_FRAME_WORDS_DEF,
  parameter int HEADER_WORDS     = rfci_pkg::HEADER_WORDS_DEF,
  parameter int COLUMNS_PER_CARD = rfci_pkg::COLUMNS_PER_CARD_DEF,
  parameter int MAX_CARDS        = rfci_pkg::MAX_CARDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rfci_pkg::WORD_W-1:0]     in_tdata,     // [31:0] word
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rfci_pkg::WORD_W-1:0]     out_tdata,    // [31:0] out_word
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rfci_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rfci_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rfci_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AW  = $clog2(MAX_FRAME_WORDS);
  localparam int LW  = $clog2(MAX_FRAME_WORDS + 1);
  localparam int HW  = $clog2(HEADER_WORDS + 2);
  localparam int EW  = ((LW > HW) ? LW : HW) + 1;
  localparam int XW  = (LW > rfci_pkg::FRAME_LEN_W) ? LW : rfci_pkg::FRAME_LEN_W;
  localparam int CLW = (COLUMNS_PER_CARD > 1) ? $clog2(COLUMNS_PER_CARD) : 1;
  localparam int NC  = (MAX_CARDS < 4) ? MAX_CARDS : 4;
  localparam int STW = $clog2(4 * COLUMNS_PER_CARD + 1);
  localparam int S   = EW + $clog2(4 * COLUMNS_PER_CARD) + 1;
  localparam int RW  = S + 1;
  localparam int PW  = EW + RW;
  localparam longint unsigned ONE_S = 64'd1 << S;
  localparam longint unsigned RECIP2 =
    (ONE_S + 2 * COLUMNS_PER_CARD - 1) / (2 * COLUMNS_PER_CARD);
  localparam longint unsigned RECIP3 =
    (ONE_S + 3 * COLUMNS_PER_CARD - 1) / (3 * COLUMNS_PER_CARD);
  localparam longint unsigned RECIP4 =
    (ONE_S + 4 * COLUMNS_PER_CARD - 1) / (4 * COLUMNS_PER_CARD);

  logic [rfci_pkg::CARD_MASK_W-1:0] card_mask_r;
  logic [rfci_pkg::FRAME_LEN_W-1:0] frame_words_r;
  logic                             cfg_wr;
  logic [rfci_pkg::REG_IDX_W-1:0]   cfg_idx;

  logic [AW-1:0]                    pos_r, pos_nxt;
  logic                             wsel_r;
  logic                             prev_ready_r;
  logic [LW-1:0]                    prev_len_r;
  logic [LW-1:0]                    len_r;
  logic [rfci_pkg::CARD_CNT_W-1:0]  cards_r;
  logic [LW-1:0]                    rows_r;

  logic [CLW-1:0]                   col_r;
  logic [LW-1:0]                    row_r;
  logic [rfci_pkg::CARD_IDX_W-1:0]  card_r;
  logic [AW-1:0]                    dbase_r;
  logic                             done_r;

  logic                             pend_r;
  logic                             pend_last_r;
  logic                             out_valid_r;
  logic [rfci_pkg::WORD_W-1:0]      out_data_r;
  logic                             out_last_r;

  logic [XW-1:0]                    fw_ext;
  logic [LW-1:0]                    len_c;
  logic [rfci_pkg::CARD_CNT_W-1:0]  cards_c;
  logic [EW-1:0]                    room_c;
  logic [RW-1:0]                    recip_c;
  logic [PW-1:0]                    prod_c;
  logic [LW-1:0]                    rows_c;

  logic                             first;
  logic [LW-1:0]                    len_eff;
  logic [rfci_pkg::CARD_CNT_W-1:0]  cards_eff;
  logic [LW-1:0]                    rows_eff;
  logic [STW-1:0]                   stride;
  logic                             in_data;
  logic [AW-1:0]                    dest;
  logic [LW-1:0]                    pos_inc;
  logic                             wrap;
  logic                             emit;
  logic                             last_word;
  logic                             in_acc;
  logic                             move;
  logic                             col_end, row_end, card_end;
  logic [EW-1:0]                    row_base_sum;
  logic [EW-1:0]                    card_base_sum;
  logic [rfci_pkg::WORD_W-1:0]      ram_rd_data;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2 +: rfci_pkg::REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_mask_r   <= rfci_pkg::CARD_MASK_RST;
      frame_words_r <= rfci_pkg::FRAME_WORDS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rfci_pkg::REG_CARD_MASK: begin
          card_mask_r <= cfg_pwdata[rfci_pkg::CARD_MASK_W-1:0];
        end
        rfci_pkg::REG_FRAME_WORDS: begin
          frame_words_r <= cfg_pwdata[rfci_pkg::FRAME_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rfci_pkg::REG_CARD_MASK:   cfg_prdata = rfci_pkg::CFG_DATA_W'(card_mask_r);
      rfci_pkg::REG_FRAME_WORDS: cfg_prdata = rfci_pkg::CFG_DATA_W'(frame_words_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Frame geometry from the registers, sampled at the first word.
  always_comb begin
    fw_ext = XW'(frame_words_r);
    if (fw_ext == '0) begin
      len_c = LW'(1);
    end else if (fw_ext > XW'(MAX_FRAME_WORDS)) begin
      len_c = LW'(MAX_FRAME_WORDS);
    end else begin
      len_c = LW'(fw_ext);
    end
  end

  always_comb begin
    cards_c = '0;
    for (int k = 0; k < NC; k++) begin
      cards_c = cards_c + rfci_pkg::CARD_CNT_W'(card_mask_r[k]);
    end
  end

  always_comb begin
    room_c = EW'(len_c) - EW'(HEADER_WORDS + 1);
    unique case (cards_c)
      3'd2:    recip_c = RW'(RECIP2);
      3'd3:    recip_c = RW'(RECIP3);
      3'd4:    recip_c = RW'(RECIP4);
      default: recip_c = '0;
    endcase
    prod_c = PW'(room_c) * PW'(recip_c);
    if (cards_c >= 3'd2 && EW'(len_c) >= EW'(HEADER_WORDS + 1)) begin
      rows_c = prod_c[S +: LW];
    end else begin
      rows_c = '0;
    end
  end

  // Per-word addressing.
  assign in_acc    = in_tvalid && in_tready;
  assign first     = (pos_r == '0);
  assign len_eff   = first ? len_c : len_r;
  assign cards_eff = first ? cards_c : cards_r;
  assign rows_eff  = first ? rows_c : rows_r;
  assign stride    = STW'(cards_eff) * STW'(COLUMNS_PER_CARD);
  assign in_data   = (EW'(pos_r) >= EW'(HEADER_WORDS)) && !done_r && (rows_eff != '0);
  assign dest      = in_data ? (dbase_r + AW'(col_r)) : pos_r;
  assign pos_inc   = LW'(pos_r) + LW'(1);
  assign wrap      = (pos_inc >= len_eff);
  assign pos_nxt   = wrap ? '0 : AW'(pos_inc);
  assign emit      = prev_ready_r && (LW'(pos_r) < prev_len_r);
  assign last_word = (pos_inc == prev_len_r) || (pos_inc == len_eff);

  assign col_end       = (col_r == CLW'(COLUMNS_PER_CARD - 1));
  assign row_end       = (row_r == rows_eff - LW'(1));
  assign card_end      = (rfci_pkg::CARD_CNT_W'(card_r) == cards_eff - 3'd1);
  assign row_base_sum  = EW'(dbase_r) + EW'(stride);
  assign card_base_sum = EW'(HEADER_WORDS) +
                         EW'(card_r + 2'd1) * EW'(COLUMNS_PER_CARD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      wsel_r       <= 1'b0;
      prev_ready_r <= 1'b0;
    end else if (in_acc) begin
      pos_r <= pos_nxt;
      if (wrap) begin
        wsel_r       <= ~wsel_r;
        prev_ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (first) begin
        len_r   <= len_c;
        cards_r <= cards_c;
        rows_r  <= rows_c;
      end
      if (wrap) begin
        prev_len_r <= len_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      card_r  <= '0;
      dbase_r <= AW'(HEADER_WORDS);
      done_r  <= 1'b0;
    end else if (in_acc) begin
      if (wrap) begin
        col_r   <= '0;
        row_r   <= '0;
        card_r  <= '0;
        dbase_r <= AW'(HEADER_WORDS);
        done_r  <= 1'b0;
      end else if (in_data) begin
        if (!col_end) begin
          col_r <= col_r + CLW'(1);
        end else begin
          col_r <= '0;
          if (!row_end) begin
            row_r   <= row_r + LW'(1);
            dbase_r <= AW'(row_base_sum);
          end else begin
            row_r   <= '0;
            card_r  <= card_r + 2'd1;
            dbase_r <= AW'(card_base_sum);
            done_r  <= card_end;
          end
        end
      end
    end
  end

  rfci_ram #(
    .WIDTH (rfci_pkg::WORD_W),
    .DEPTH (2 * MAX_FRAME_WORDS)
  ) u_bank (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr ({wsel_r, dest}),
    .wr_data (in_tdata),
    .rd_en   (in_acc && emit),
    .rd_addr ({~wsel_r, pos_r}),
    .rd_data (ram_rd_data)
  );

  // Read in flight, then output register.
  assign move      = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && emit) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      pend_last_r <= last_word;
    end
    if (move) begin
      out_data_r <= ram_rd_data;
      out_last_r <= pend_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_emit_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> pend_r)
    else $error("Emitted beat did not leave a read in flight.");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) |-> (LW'(pos_r) < len_r))
    else $error("Word position ran past the latched frame length.");

  a_wrap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wrap) |=> ((pos_r == '0) && prev_ready_r && (wsel_r != $past(wsel_r))))
    else $error("Frame end did not restart the position and swap banks.");

  a_dest_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data) |-> (LW'(dest) < len_eff))
    else $error("Interleaved address lies outside the frame.");

endmodule
